>>> sv/assert_macros.svh
// Assertion macros shared by the heap RTL.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a implies b on the same edge.
`define ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Check that a implies b on the next edge.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

>>> sv/ibh_pkg.sv
// Package for the indexed binary heap: widths, status and kind codes, states.
// No dependencies.
`default_nettype none
package ibh_pkg;
  localparam int MaxIdsDefault = 1024;
  localparam int IdW  = 10;
  localparam int KeyW = 32;
  localparam int CntW = 11;

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0, KIND_POP = 2'd1, KIND_CHANGE = 2'd2, KIND_QUERY = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DUP = 2'd1, ST_EMPTY = 2'd2, ST_ABSENT = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CHK, S_UP, S_UP1, S_UP2, S_DN, S_DN1, S_DN2, S_DN3,
    S_DN4, S_POP1, S_POP2, S_POP3, S_TOP, S_TOP1, S_TOP2
  } state_t;
endpackage
`default_nettype wire

>>> sv/indexed_binary_heap.sv
// Indexed binary heap priority queue of item ids with per-id keys. After reset
// the block clears its presence map, with ready low. Then one request is
// taken at a time: ready is low while it runs. A request is checked, then a
// push or a rekey sifts up (a rekey that does not rise then sifts down), a pop
// moves the last slot to the root and sifts it down, and the top is read for
// the result. The single comparator and the one read port of each memory
// (slot array, position map, key store, presence map) set this pace. The
// result sits in an output register, so the next request can be taken while
// it waits; a new result waits until the old one transfers.
// Depends on ibh_pkg, ibh_cmp and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module indexed_binary_heap import ibh_pkg::*; #(
  parameter int MAX_IDS = MaxIdsDefault
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_wdata,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             kind,
  input  wire logic [IdW-1:0]         item_id,
  input  wire logic signed [KeyW-1:0] item_key,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  status,
  output logic [IdW-1:0]              top_id,
  output logic signed [KeyW-1:0]      top_key,
  output logic [CntW-1:0]             count,
  output logic                        id_present,
  output logic                        is_empty
);
  localparam int AW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int NW = $clog2(MAX_IDS + 1);
  localparam int PW = AW + 1;

  // Storage
  logic [IdW-1:0]  slots  [MAX_IDS];
  logic [AW-1:0]   pos_of [MAX_IDS];
  logic [KeyW-1:0] keys   [MAX_IDS];
  logic            vld    [MAX_IDS];
  logic [IdW-1:0]  slot_rd;
  logic [AW-1:0]   pos_rd;
  logic [KeyW-1:0] key_rd;
  logic            vld_rd;
  logic [NW-1:0]   held;
  logic            largest_first;

  state_t          state, state_next;
  logic [AW-1:0]   clr_addr;
  kind_t           rq_kind;
  logic [IdW-1:0]  rq_id;
  logic [KeyW-1:0] rq_key;
  logic            rq_inrange;
  status_t         st;
  logic            present;
  logic [IdW-1:0]  mover;
  logic [KeyW-1:0] mkey;
  logic [AW-1:0]   pos;
  logic [AW-1:0]   child;
  logic            rose;
  logic [IdW-1:0]  oth_id, ch_id;
  logic [KeyW-1:0] ch_key;

  // Memory port control (one read, one write per memory per cycle)
  logic [AW-1:0]   slot_ra, slot_wa, posm_ra, posm_wa, key_ra, key_wa, vld_ra, vld_wa;
  logic            slot_we, posm_we, key_we, vld_we;
  logic [IdW-1:0]  slot_wd;
  logic [AW-1:0]   posm_wd;
  logic [KeyW-1:0] key_wd;
  logic            vld_wd;

  // Shared compare unit
  logic signed [KeyW-1:0] cmp_a, cmp_b;
  logic cmp_above;
  ibh_cmp u_cmp (.largest_first(largest_first), .key_a(cmp_a), .key_b(cmp_b),
                 .above(cmp_above));

  // Memories with registered read data
  always_ff @(posedge clk) begin
    if (slot_we) slots[slot_wa] <= slot_wd;
    slot_rd <= slots[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (posm_we) pos_of[posm_wa] <= posm_wd;
    pos_rd <= pos_of[posm_ra];
  end

  always_ff @(posedge clk) begin
    if (key_we) keys[key_wa] <= key_wd;
    key_rd <= keys[key_ra];
  end

  always_ff @(posedge clk) begin
    if (vld_we) vld[vld_wa] <= vld_wd;
    vld_rd <= vld[vld_ra];
  end

  logic in_fire, out_fire, load_out;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = (state == S_IDLE);
  assign load_out = (state == S_TOP2) && (!out_valid || out_ready);

  logic [AW-1:0] up_pos;
  logic [PW-1:0] lchild, rchild;
  assign up_pos = (pos - AW'(1)) >> 1;
  assign lchild = {pos, 1'b1};
  assign rchild = lchild + PW'(1);

  // Request checks, valid in the check state
  logic cur_valid, push_ok;
  status_t chk_st;
  assign cur_valid = rq_inrange && vld_rd;
  assign push_ok = (rq_kind == KIND_PUSH) && rq_inrange && !vld_rd &&
                   (held < NW'(MAX_IDS));

  always_comb begin
    chk_st = ST_OK;
    case (rq_kind)
      KIND_PUSH: begin
        if (!rq_inrange) chk_st = ST_ABSENT;
        else if (vld_rd) chk_st = ST_DUP;
      end
      KIND_POP: if (held == '0) chk_st = ST_EMPTY;
      KIND_CHANGE: if (!cur_valid) chk_st = ST_ABSENT;
      default: ;
    endcase
  end

  // Next state, memory controls and compare operands
  always_comb begin
    state_next = state;
    slot_ra = '0; slot_we = 1'b0; slot_wa = pos; slot_wd = mover;
    posm_ra = AW'(item_id); posm_we = 1'b0; posm_wa = AW'(mover); posm_wd = pos;
    key_ra = '0; key_we = 1'b0; key_wa = AW'(rq_id); key_wd = rq_key;
    vld_ra = AW'(item_id); vld_we = 1'b0; vld_wa = AW'(rq_id); vld_wd = 1'b0;
    cmp_a = mkey; cmp_b = key_rd;
    case (state)
      S_CLEAR: begin
        vld_we = 1'b1; vld_wa = clr_addr;
        if (clr_addr == AW'(MAX_IDS - 1)) state_next = S_IDLE;
      end
      S_IDLE: if (in_fire) state_next = S_CHK;
      S_CHK: begin
        state_next = S_TOP;
        if (push_ok) begin
          key_we = 1'b1; vld_we = 1'b1; vld_wd = 1'b1;
          state_next = S_UP;
        end else if (rq_kind == KIND_POP && held != '0) begin
          state_next = S_POP1;
        end else if (rq_kind == KIND_CHANGE && cur_valid) begin
          key_we = 1'b1;
          state_next = S_UP;
        end
      end
      S_UP: begin
        if (pos == '0) begin
          slot_we = 1'b1; posm_we = 1'b1;
          state_next = (rq_kind == KIND_CHANGE && !rose) ? S_DN : S_TOP;
        end else begin
          slot_ra = up_pos;
          state_next = S_UP1;
        end
      end
      S_UP1: begin
        key_ra = AW'(slot_rd);
        state_next = S_UP2;
      end
      S_UP2: begin
        slot_we = 1'b1; posm_we = 1'b1;
        if (cmp_above) begin
          slot_wd = oth_id; posm_wa = AW'(oth_id);
          state_next = S_UP;
        end else begin
          state_next = (rq_kind == KIND_CHANGE && !rose) ? S_DN : S_TOP;
        end
      end
      S_DN: begin
        if (lchild >= PW'(held)) begin
          slot_we = 1'b1; posm_we = 1'b1;
          state_next = S_TOP;
        end else begin
          slot_ra = AW'(lchild);
          state_next = S_DN1;
        end
      end
      S_DN1: begin
        key_ra = AW'(slot_rd);
        slot_ra = AW'(rchild);
        state_next = S_DN2;
      end
      S_DN2: begin
        if (rchild < PW'(held)) key_ra = AW'(slot_rd);
        state_next = S_DN3;
      end
      S_DN3: begin
        // right child against left child
        cmp_a = key_rd; cmp_b = ch_key;
        state_next = S_DN4;
      end
      S_DN4: begin
        cmp_a = ch_key; cmp_b = mkey;
        slot_we = 1'b1; posm_we = 1'b1;
        if (cmp_above) begin
          slot_wd = ch_id; posm_wa = AW'(ch_id);
          state_next = S_DN;
        end else begin
          state_next = S_TOP;
        end
      end
      S_POP1: begin
        vld_we = 1'b1; vld_wa = AW'(slot_rd);
        if (held == NW'(1)) begin
          state_next = S_TOP;
        end else begin
          slot_ra = AW'(held - NW'(1));
          state_next = S_POP2;
        end
      end
      S_POP2: begin
        key_ra = AW'(slot_rd);
        state_next = S_POP3;
      end
      S_POP3: state_next = S_DN;
      S_TOP: state_next = S_TOP1;
      S_TOP1: begin
        key_ra = AW'(slot_rd);
        state_next = S_TOP2;
      end
      S_TOP2: begin
        key_ra = AW'(oth_id);
        if (load_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      held <= '0;
      largest_first <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) largest_first <= cfg_wdata;
      if (load_out) out_valid <= 1'b1;
      else if (out_fire) out_valid <= 1'b0;
      case (state)
        S_CLEAR: clr_addr <= clr_addr + AW'(1);
        S_IDLE: if (in_fire) begin
          rq_kind <= kind_t'(kind); rq_id <= item_id; rq_key <= item_key;
          rq_inrange <= (int'(item_id) < MAX_IDS);
          rose <= 1'b0;
        end
        S_CHK: begin
          mover <= rq_id; mkey <= rq_key;
          st <= chk_st;
          present <= cur_valid || push_ok;
          if (push_ok) begin
            pos <= AW'(held);
            held <= held + NW'(1);
          end else if (rq_kind == KIND_CHANGE) begin
            pos <= pos_rd;
          end
        end
        S_UP1: oth_id <= slot_rd;
        S_UP2: if (cmp_above) begin
          pos <= up_pos; rose <= 1'b1;
        end
        S_DN1: begin
          ch_id <= slot_rd; child <= AW'(lchild);
        end
        S_DN2: begin
          ch_key <= key_rd; oth_id <= slot_rd;
        end
        S_DN3: if (rchild < PW'(held) && cmp_above) begin
          ch_id <= oth_id; ch_key <= key_rd; child <= AW'(rchild);
        end
        S_DN4: if (cmp_above) pos <= child;
        S_POP1: begin
          held <= held - NW'(1);
          if (slot_rd == rq_id) present <= 1'b0;
        end
        S_POP2: begin
          mover <= slot_rd; pos <= '0;
        end
        S_POP3: mkey <= key_rd;
        S_TOP1: oth_id <= slot_rd;
        S_TOP2: if (load_out) begin
          status <= st;
          top_id <= (held != '0) ? oth_id : '0;
          top_key <= (held != '0) ? key_rd : '0;
          count <= CntW'(held);
          id_present <= present;
          is_empty <= (held == '0);
        end
        default: ;
      endcase
    end
  end

  // Checks
  `ASSERT_IMP(a_ready_idle, clk, rst, in_ready, state == S_IDLE)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(top_key) && $stable(status))
  `ASSERT_IMP(a_cnt, clk, rst, out_valid, is_empty == (count == '0))
  `ASSERT_IMP(a_held_max, clk, rst, 1'b1, held <= NW'(MAX_IDS))
endmodule
`default_nettype wire

>>> sv/ibh_cmp.sv
// Shared key comparator of the heap: strict rank test under the ordering mode.
// Depends on ibh_pkg.
`default_nettype none
module ibh_cmp import ibh_pkg::*; (
  input  wire logic                   largest_first,
  input  wire logic signed [KeyW-1:0] key_a,
  input  wire logic signed [KeyW-1:0] key_b,
  output logic                        above
);
  // a ranks strictly above b
  assign above = largest_first ? (key_a > key_b) : (key_a < key_b);
endmodule
`default_nettype wire

>>> tb/ibh_checker.sv
// Scoreboard for the indexed binary heap: mirrors the heap, predicts each result.
// Depends on ibh_pkg; watches the request, result and mode-register ports.
`timescale 1ns / 1ps
module ibh_checker import ibh_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_wdata,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [1:0]             kind,
  input  logic [IdW-1:0]         item_id,
  input  logic signed [KeyW-1:0] item_key,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [1:0]             status,
  input  logic [IdW-1:0]         top_id,
  input  logic signed [KeyW-1:0] top_key,
  input  logic [CntW-1:0]        count,
  input  logic                   id_present,
  input  logic                   is_empty,
  output int                     errors,
  output int                     pending,
  output int                     results_seen
);
  localparam int QDepth = 8;

  typedef struct packed {
    status_t                st;
    logic [IdW-1:0]         id;
    logic signed [KeyW-1:0] key;
    logic [CntW-1:0]        cnt;
    logic                   present;
    logic                   empty;
  } heap_result_t;

  // Mirror of the heap state
  logic [IdW-1:0]         slot_id [MaxIdsDefault];
  logic [IdW-1:0]         id_slot [MaxIdsDefault];
  logic signed [KeyW-1:0] id_key  [MaxIdsDefault];
  logic                   held    [MaxIdsDefault];
  int                     held_n;
  logic                   max_on_top;

  // Ring of predicted results in transfer order
  heap_result_t           awaited [QDepth];
  int                     wr_ptr, rd_ptr, n_wait;

  function automatic logic outranks(logic [IdW-1:0] a, logic [IdW-1:0] b);
    return max_on_top ? (id_key[a] > id_key[b]) : (id_key[a] < id_key[b]);
  endfunction

  function automatic int sift_up(int pos);
    logic [IdW-1:0] mover;
    int parent;
    mover = slot_id[pos];
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if (!outranks(mover, slot_id[parent])) break;
      slot_id[pos] = slot_id[parent];
      id_slot[slot_id[parent]] = IdW'(pos);
      pos = parent;
    end
    slot_id[pos] = mover;
    id_slot[mover] = IdW'(pos);
    return pos;
  endfunction

  function automatic void sift_down(int pos, int n);
    logic [IdW-1:0] mover;
    int child;
    mover = slot_id[pos];
    child = 2 * pos + 1;
    while (child < n) begin
      if (child + 1 < n && outranks(slot_id[child + 1], slot_id[child])) child++;
      if (!outranks(slot_id[child], mover)) break;
      slot_id[pos] = slot_id[child];
      id_slot[slot_id[child]] = IdW'(pos);
      pos = child;
      child = 2 * pos + 1;
    end
    slot_id[pos] = mover;
    id_slot[mover] = IdW'(pos);
  endfunction

  function automatic heap_result_t apply_request(kind_t k, logic [IdW-1:0] id,
                                                 logic signed [KeyW-1:0] key);
    heap_result_t r;
    int start;
    r.st = ST_OK;
    case (k)
      KIND_PUSH: begin
        if (held[id]) r.st = ST_DUP;
        else if (held_n < MaxIdsDefault) begin
          id_key[id] = key;
          held[id] = 1'b1;
          slot_id[held_n] = id;
          id_slot[id] = IdW'(held_n);
          held_n++;
          void'(sift_up(held_n - 1));
        end
      end
      KIND_POP: begin
        if (held_n == 0) r.st = ST_EMPTY;
        else begin
          held[slot_id[0]] = 1'b0;
          held_n--;
          if (held_n > 0) begin
            slot_id[0] = slot_id[held_n];
            id_slot[slot_id[0]] = '0;
            sift_down(0, held_n);
          end
        end
      end
      KIND_CHANGE: begin
        if (!held[id]) r.st = ST_ABSENT;
        else begin
          start = id_slot[id];
          id_key[id] = key;
          if (sift_up(start) == start) sift_down(start, held_n);
        end
      end
      default: ;
    endcase
    r.id = held_n > 0 ? slot_id[0] : '0;
    r.key = held_n > 0 ? id_key[slot_id[0]] : '0;
    r.cnt = held_n[CntW-1:0];
    r.present = held[id];
    r.empty = (held_n == 0);
    return r;
  endfunction

  assign pending = n_wait;

  always @(posedge clk) begin
    heap_result_t exp_r;
    if (rst) begin
      foreach (held[i]) held[i] = 1'b0;
      held_n = 0;
      max_on_top = 1'b1;
      wr_ptr = 0;
      rd_ptr = 0;
      n_wait = 0;
      errors = 0;
      results_seen = 0;
    end else begin
      // Compare a finished transfer against the oldest prediction
      if (out_valid && out_ready) begin
        results_seen++;
        if (n_wait == 0) begin
          $display("%0t: unexpected result transfer, status %0d", $time, status);
          errors++;
        end else begin
          exp_r = awaited[rd_ptr];
          rd_ptr = (rd_ptr + 1) % QDepth;
          n_wait--;
          if (status !== exp_r.st) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.st, status);
            errors++;
          end
          if (top_id !== exp_r.id) begin
            $display("%0t: top_id expected %0d actual %0d", $time, exp_r.id, top_id);
            errors++;
          end
          if (top_key !== exp_r.key) begin
            $display("%0t: top_key expected %0d actual %0d", $time, exp_r.key, top_key);
            errors++;
          end
          if (count !== exp_r.cnt) begin
            $display("%0t: count expected %0d actual %0d", $time, exp_r.cnt, count);
            errors++;
          end
          if (id_present !== exp_r.present) begin
            $display("%0t: id_present expected %0b actual %0b", $time, exp_r.present,
                     id_present);
            errors++;
          end
          if (is_empty !== exp_r.empty) begin
            $display("%0t: is_empty expected %0b actual %0b", $time, exp_r.empty,
                     is_empty);
            errors++;
          end
        end
      end
      // Track the ordering mode
      if (cfg_we) max_on_top = cfg_wdata;
      // Predict each accepted request
      if (in_valid && in_ready) begin
        if (n_wait == QDepth) begin
          $display("%0t: too many results outstanding, expected at most %0d actual %0d",
                   $time, QDepth, n_wait + 1);
          errors++;
        end else begin
          awaited[wr_ptr] = apply_request(kind_t'(kind), item_id, item_key);
          wr_ptr = (wr_ptr + 1) % QDepth;
          n_wait++;
        end
      end
    end
  end
endmodule

>>> tb/indexed_binary_heap_test.sv
// Top of the heap testbench: clock, reset, request stimulus, mode writes, verdict.
// Depends on ibh_pkg, ibh_checker and the indexed_binary_heap RTL.
`timescale 1ns / 1ps
module indexed_binary_heap_test;
  import ibh_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 80;
  localparam int RecentDepth = 64;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic                   cfg_wdata = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             kind = KIND_QUERY;
  logic [IdW-1:0]         item_id = '0;
  logic signed [KeyW-1:0] item_key = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             status;
  logic [IdW-1:0]         top_id;
  logic signed [KeyW-1:0] top_key;
  logic [CntW-1:0]        count;
  logic                   id_present;
  logic                   is_empty;
  int                     errors, pending, results_seen;
  int                     cycles = 0;
  bit                     calm = 1'b0;
  int                     sent = 0;
  logic [IdW-1:0]         recent_ids [RecentDepth];
  int                     recent_n = 0;
  int                     recent_wr = 0;

  always #6 clk = ~clk;

  indexed_binary_heap dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .item_id(item_id),
    .item_key(item_key), .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .top_id(top_id), .top_key(top_key), .count(count),
    .id_present(id_present), .is_empty(is_empty)
  );

  ibh_checker scoreboard (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .item_id(item_id),
    .item_key(item_key), .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .top_id(top_id), .top_key(top_key), .count(count),
    .id_present(id_present), .is_empty(is_empty), .errors(errors),
    .pending(pending), .results_seen(results_seen)
  );

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stall the result side in random bursts
  always @(negedge clk) begin
    int gap;
    if (!rst) begin
      if (!calm && $urandom_range(3) == 0) begin
        gap = $urandom_range(9, 1);
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      if (!calm && $urandom_range(1) == 0) repeat ($urandom_range(30, 5)) @(negedge clk);
    end
  end

  // Hold one request until its transfer; idle in random bursts before it
  task automatic send_request(kind_t k, logic [IdW-1:0] id, logic signed [KeyW-1:0] key);
    if (!calm && $urandom_range(3) == 0) repeat ($urandom_range(9, 1)) @(negedge clk);
    kind = k;
    item_id = id;
    item_key = key;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
    if (k == KIND_PUSH) begin
      recent_ids[recent_wr] = id;
      recent_wr = (recent_wr + 1) % RecentDepth;
      if (recent_n < RecentDepth) recent_n++;
    end
    sent++;
  endtask

  // Write the ordering mode once all results are back
  task automatic set_order(logic largest);
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = largest;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic signed [KeyW-1:0] pick_key();
    case ($urandom_range(3))
      0: return $signed($urandom_range(8)) - 4;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int n);
    int r;
    logic [IdW-1:0] id;
    repeat (n) begin
      r = $urandom_range(99);
      id = (recent_n > 0 && $urandom_range(1)) ?
           recent_ids[$urandom_range(recent_n - 1)] : IdW'($urandom_range(1023));
      if (r < 50) send_request(KIND_PUSH, r < 42 ? IdW'($urandom_range(1023)) : id,
                               pick_key());
      else if (r < 72) send_request(KIND_POP, IdW'($urandom_range(1023)), $urandom);
      else if (r < 92) send_request(KIND_CHANGE, id, pick_key());
      else send_request(KIND_QUERY, id, $urandom);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty cases, extreme ids and keys, ties, rekeys both ways
    set_order(1'b1);
    send_request(KIND_POP, 10'd0, 32'sd0);
    send_request(KIND_CHANGE, 10'd5, 32'sd7);
    send_request(KIND_QUERY, 10'd1023, 32'sd0);
    send_request(KIND_PUSH, 10'd0, 32'sh80000000);
    send_request(KIND_PUSH, 10'd1023, 32'sh7fffffff);
    send_request(KIND_PUSH, 10'd1023, 32'sd1);
    send_request(KIND_PUSH, 10'd512, 32'sd0);
    send_request(KIND_PUSH, 10'd3, -32'sd1);
    send_request(KIND_PUSH, 10'd4, 32'sd0);
    send_request(KIND_PUSH, 10'd341, 32'sh7fffffff);
    send_request(KIND_QUERY, 10'd341, 32'sd0);
    send_request(KIND_CHANGE, 10'd0, 32'sh7fffffff);
    send_request(KIND_CHANGE, 10'd1023, 32'sh80000000);
    send_request(KIND_CHANGE, 10'd4, 32'sd0);
    send_request(KIND_POP, 10'd0, 32'sd0);
    send_request(KIND_POP, 10'd341, 32'sd0);
    set_order(1'b0);
    send_request(KIND_PUSH, 10'd682, -32'sd5);
    send_request(KIND_CHANGE, 10'd512, 32'sh80000000);
    send_request(KIND_POP, 10'd512, 32'sd0);
    repeat (6) send_request(KIND_POP, 10'd3, 32'sd0);

    // Random: ordering flips with ids still held
    random_phase(180);
    set_order(1'b1);
    random_phase(180);
    set_order(1'b0);
    calm = 1'b1;
    random_phase(120);

    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);
    $display("covered %0d requests and %0d results in %0d cycles,", sent, results_seen,
             cycles);
    $display("both orderings, empty and duplicate cases, extreme ids and keys");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
